// ===== rtl/core/wfs_pkg.sv =====
// ----------------------------------------------------------------------------
// wfs_pkg
// Types and constants for the wire-format field scanner: beat structs,
// scan phase codes, wire types and error codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wfs_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [28:0] field_number;
        logic [2:0]  wtype;
        logic [63:0] value;
        logic        is_payload;
        logic [1:0]  error_code;
        logic        message_end;
    } out_beat_t;

    typedef struct packed {
        logic      present;
        out_beat_t beat;
    } scan_result_t;

    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIX64   = 3'd2;
    localparam logic [2:0] PH_FIX32   = 3'd3;
    localparam logic [2:0] PH_LENGTH  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DRAIN   = 3'd6;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIX64   = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIX32   = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [1:0] ERR_WIRE_TYPE = 2'd3;

    localparam logic [3:0] TAG_MAX_BYTES    = 4'd5;
    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
    localparam logic [3:0] FIX64_BYTES      = 4'd8;
    localparam logic [3:0] FIX32_BYTES      = 4'd4;

    localparam logic [7:0] CONT_MASK = 8'h80;
    localparam logic [7:0] LOW_MASK  = 8'h7f;

endpackage

`default_nettype wire

// ===== rtl/core/wfs_scan.sv =====
// ----------------------------------------------------------------------------
// wfs_scan
// Byte-level scan state and decode: tag, varint, fixed and length
// assembly, payload pass-through and error drain, one byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module wfs_scan (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire wfs_pkg::in_beat_t     beat,
    output wfs_pkg::scan_result_t      result
);
    import wfs_pkg::*;

    logic [2:0]  phase_reg,   phase_next;
    logic [3:0]  count_reg,   count_next;
    logic [63:0] acc_reg,     acc_next;
    logic [28:0] field_reg,   field_next;
    logic [2:0]  wire_reg,    wire_next;
    logic [31:0] left_reg,    left_next;

    logic [6:0]  low7;
    logic        more;
    logic        last;
    logic [3:0]  cnt_inc;
    logic [6:0]  sh7_amt;
    logic [5:0]  sh8_amt;
    logic [63:0] sh7;
    logic [63:0] sh8;
    logic [31:0] acc32;
    logic [31:0] left_dec;

    logic        emit;
    logic        go_payload;
    logic [28:0] e_fn;
    logic [2:0]  e_wt;
    logic [63:0] e_val;
    logic        e_pay;
    logic [1:0]  e_err;
    logic        e_end;

    assign low7     = beat.data_byte[6:0] & LOW_MASK[6:0];
    assign more     = (beat.data_byte & CONT_MASK) != 8'd0;
    assign last     = beat.last_byte;
    assign cnt_inc  = count_reg + 4'd1;
    assign sh7_amt  = 7'(count_reg) * 7'd7;
    assign sh8_amt  = {count_reg[2:0], 3'b000};
    assign sh7      = {57'd0, low7} << sh7_amt;
    assign sh8      = {56'd0, beat.data_byte} << sh8_amt;
    assign acc32    = acc_reg[31:0] | ((count_reg < TAG_MAX_BYTES) ? sh7[31:0] : 32'd0);
    assign left_dec = left_reg - 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        field_next = field_reg;
        wire_next  = wire_reg;
        left_next  = left_reg;
        emit       = 1'b0;
        go_payload = 1'b0;
        e_fn       = field_reg;
        e_wt       = wire_reg;
        e_val      = 64'd0;
        e_pay      = 1'b0;
        e_err      = ERR_NONE;
        e_end      = last;

        case (phase_reg)
            PH_TAG, PH_LENGTH:
            begin
                if (phase_reg == PH_TAG)
                begin
                    e_fn = 29'd0;
                    e_wt = 3'd0;
                end
                acc_next   = {32'd0, acc32};
                count_next = cnt_inc;
                if (more)
                begin
                    if (last)
                    begin
                        emit  = 1'b1;
                        e_err = ERR_TRUNCATED;
                    end
                    else if (cnt_inc >= TAG_MAX_BYTES)
                    begin
                        emit  = 1'b1;
                        e_err = ERR_TOO_LONG;
                    end
                end
                else if (phase_reg == PH_TAG)
                begin
                    field_next = acc32[31:3];
                    wire_next  = acc32[2:0];
                    acc_next   = 64'd0;
                    count_next = 4'd0;
                    e_fn       = acc32[31:3];
                    e_wt       = acc32[2:0];
                    case (acc32[2:0])
                        WT_VARINT: phase_next = PH_VARINT;
                        WT_FIX64:  phase_next = PH_FIX64;
                        WT_LENGTH: phase_next = PH_LENGTH;
                        WT_FIX32:  phase_next = PH_FIX32;
                        default:
                        begin
                            emit  = 1'b1;
                            e_err = ERR_WIRE_TYPE;
                        end
                    endcase
                    if (!emit && last)
                    begin
                        emit  = 1'b1;
                        e_err = ERR_TRUNCATED;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    if (acc32 != 32'd0)
                    begin
                        if (last)
                        begin
                            e_err = ERR_TRUNCATED;
                        end
                        else
                        begin
                            e_val      = {32'd0, acc32};
                            go_payload = 1'b1;
                        end
                    end
                end
            end
            PH_VARINT:
            begin
                if (count_reg < VARINT_MAX_BYTES)
                begin
                    acc_next = acc_reg | sh7;
                end
                count_next = cnt_inc;
                if (more)
                begin
                    if (last)
                    begin
                        emit  = 1'b1;
                        e_err = ERR_TRUNCATED;
                    end
                    else if (cnt_inc >= VARINT_MAX_BYTES)
                    begin
                        emit  = 1'b1;
                        e_err = ERR_TOO_LONG;
                    end
                end
                else
                begin
                    emit  = 1'b1;
                    e_val = acc_next;
                end
            end
            PH_FIX64, PH_FIX32:
            begin
                if (count_reg < FIX64_BYTES)
                begin
                    acc_next = acc_reg | sh8;
                end
                count_next = cnt_inc;
                if (cnt_inc >= ((phase_reg == PH_FIX64) ? FIX64_BYTES : FIX32_BYTES))
                begin
                    emit  = 1'b1;
                    e_val = acc_next;
                end
                else if (last)
                begin
                    emit  = 1'b1;
                    e_err = ERR_TRUNCATED;
                end
            end
            PH_PAYLOAD:
            begin
                emit  = 1'b1;
                e_val = {56'd0, beat.data_byte};
                e_pay = 1'b1;
                if (left_dec != 32'd0)
                begin
                    if (last)
                    begin
                        e_err = ERR_TRUNCATED;
                    end
                    else
                    begin
                        go_payload = 1'b1;
                    end
                end
            end
            default:
            begin
                if (last)
                begin
                    phase_next = PH_TAG;
                    count_next = 4'd0;
                    acc_next   = 64'd0;
                    left_next  = 32'd0;
                end
            end
        endcase

        if (emit)
        begin
            count_next = 4'd0;
            acc_next   = 64'd0;
            left_next  = 32'd0;
            phase_next = (!last && (e_err != ERR_NONE)) ? PH_DRAIN : PH_TAG;
            if (go_payload)
            begin
                phase_next = PH_PAYLOAD;
                left_next  = (phase_reg == PH_PAYLOAD) ? left_dec : acc32;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            count_reg <= 4'd0;
            acc_reg   <= 64'd0;
            field_reg <= 29'd0;
            wire_reg  <= 3'd0;
            left_reg  <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            field_reg <= field_next;
            wire_reg  <= wire_next;
            left_reg  <= left_next;
        end
    end

    always_comb
    begin
        result.present          = emit;
        result.beat.field_number = e_fn;
        result.beat.wtype        = e_wt;
        result.beat.value        = e_val;
        result.beat.is_payload   = e_pay;
        result.beat.error_code   = e_err;
        result.beat.message_end  = e_end;
    end

endmodule

`default_nettype wire

// ===== rtl/core/wfs_out_reg.sv =====
// ----------------------------------------------------------------------------
// wfs_out_reg
// Result register for the scanner: holds one result beat until the
// receiver takes it, and frees in the same cycle the beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module wfs_out_reg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire wfs_pkg::scan_result_t result,
    output logic                       free,
    output logic                       field_valid,
    input  wire logic                  field_ready,
    output wfs_pkg::out_beat_t         field_beat
);
    import wfs_pkg::*;

    logic      valid_reg, valid_next;
    out_beat_t beat_reg;

    assign free        = !valid_reg || field_ready;
    assign field_valid = valid_reg;
    assign field_beat  = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = result.present;
        end
        else if (field_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.present)
        begin
            beat_reg <= result.beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wire_field_scanner_top.sv =====
// ----------------------------------------------------------------------------
// wire_field_scanner_top
// Scans a wire-format message one byte per beat and reports each field's
// number, wire type and value, each delimited payload byte, and errors.
//
// byte channel (byte_valid / byte_ready / byte_beat): one message byte per
// beat, with last_byte high on the message's final byte.
// field channel (field_valid / field_ready / field_beat): zero or one result
// beat per byte beat, in byte order.
// A result appears on the field channel in the cycle after the byte that
// causes it is taken. Throughput: one byte per cycle while the receiver keeps
// up, set by the single decode stage between the scan state and result registers.
// byte_ready is high while the result register is empty or is being taken
// in the same cycle; when the receiver stalls with a result held, byte_ready
// drops and no byte is taken until field_ready returns.
// Bytes inside a tag or value, and bytes dropped after an error, are taken
// but give no result beat.
// Reset: the scanner waits for a tag, its counters and accumulator are
// cleared and the result register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module wire_field_scanner_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire wfs_pkg::in_beat_t  byte_beat,
    output logic                    field_valid,
    input  wire logic               field_ready,
    output wfs_pkg::out_beat_t      field_beat
);
    import wfs_pkg::*;

    logic         accept;
    logic         free;
    scan_result_t result;

    assign byte_ready = free;
    assign accept     = byte_valid && free;

    wfs_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (byte_beat),
        .result (result)
    );

    wfs_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .result      (result),
        .free        (free),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .field_beat  (field_beat)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives wire_field_scanner_top with whole messages, one byte per beat: short
// directed messages for field extremes, every wire type and each error path,
// then random messages, mostly well formed with random content, some cut
// short, malformed or pure noise. A local decoder predicts every result beat,
// and each beat on the field channel is checked in order against it. Both
// channels idle at random, first one heavy and then the other, then neither.
// ----------------------------------------------------------------------------

module testbench;

    import wfs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BYTES = 265;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_ready;
    in_beat_t           byte_beat = '0;
    logic               field_valid;
    logic               field_ready = 1'b0;
    out_beat_t          field_beat;

    int                 sender_idle_pct = 0;
    int                 sink_idle_pct = 0;
    int                 fail_count = 0;
    int                 bytes_sent = 0;
    int                 stall_cycles = 0;

    out_beat_t          expected_fields[$];
    logic [7:0]         msg_bytes[$];

    logic [2:0]         scan_phase = PH_TAG;
    logic [3:0]         scan_count = '0;
    logic [63:0]        scan_acc = '0;
    logic [28:0]        cur_field = '0;
    logic [2:0]         cur_wire = '0;
    logic [31:0]        payload_due = '0;

    wire_field_scanner_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_beat   (byte_beat),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .field_beat  (field_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // field decoder
    // ------------------------------------------------------------------
    function automatic out_beat_t close_field(input logic [28:0] fn, input logic [2:0] wt,
                                              input logic [63:0] val, input logic pay,
                                              input logic [1:0] err, input logic fin);
        out_beat_t ob;
        ob.field_number = fn;
        ob.wtype        = wt;
        ob.value        = val;
        ob.is_payload   = pay;
        ob.error_code   = err;
        ob.message_end  = fin;
        scan_phase  = (!fin && err != ERR_NONE) ? PH_DRAIN : PH_TAG;
        scan_count  = '0;
        scan_acc    = '0;
        payload_due = '0;
        return ob;
    endfunction

    function automatic bit decode_byte(input in_beat_t ib, output out_beat_t ob);
        logic [7:0]  b;
        logic        fin;
        logic        more;
        logic [63:0] low;
        logic [3:0]  n;
        logic [28:0] fn;
        logic [2:0]  wt;
        logic [31:0] len;
        logic [31:0] left;
        logic [3:0]  need;
        b    = ib.data_byte;
        fin  = ib.last_byte;
        more = (b & CONT_MASK) != 8'h00;
        low  = 64'(b & LOW_MASK);
        n    = scan_count;
        ob   = '0;
        case (scan_phase)
            PH_TAG, PH_LENGTH:
            begin
                fn = (scan_phase == PH_TAG) ? 29'd0 : cur_field;
                wt = (scan_phase == PH_TAG) ? 3'd0 : cur_wire;
                if (n < TAG_MAX_BYTES)
                    scan_acc = (scan_acc | (low << (7 * n))) & 64'hFFFF_FFFF;
                scan_count = n + 4'd1;
                if (more)
                begin
                    if (fin)
                    begin
                        ob = close_field(fn, wt, '0, 1'b0, ERR_TRUNCATED, fin);
                        return 1'b1;
                    end
                    if (scan_count >= TAG_MAX_BYTES)
                    begin
                        ob = close_field(fn, wt, '0, 1'b0, ERR_TOO_LONG, fin);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (scan_phase == PH_TAG)
                begin
                    cur_field  = scan_acc[31:3];
                    cur_wire   = scan_acc[2:0];
                    scan_acc   = '0;
                    scan_count = '0;
                    case (cur_wire)
                        WT_VARINT: scan_phase = PH_VARINT;
                        WT_FIX64:  scan_phase = PH_FIX64;
                        WT_LENGTH: scan_phase = PH_LENGTH;
                        WT_FIX32:  scan_phase = PH_FIX32;
                        default:
                        begin
                            ob = close_field(cur_field, cur_wire, '0, 1'b0, ERR_WIRE_TYPE, fin);
                            return 1'b1;
                        end
                    endcase
                    if (fin)
                    begin
                        ob = close_field(cur_field, cur_wire, '0, 1'b0, ERR_TRUNCATED, fin);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                len = scan_acc[31:0];
                if (len == 32'd0)
                begin
                    ob = close_field(fn, wt, '0, 1'b0, ERR_NONE, fin);
                    return 1'b1;
                end
                if (fin)
                begin
                    ob = close_field(fn, wt, '0, 1'b0, ERR_TRUNCATED, fin);
                    return 1'b1;
                end
                ob = close_field(fn, wt, 64'(len), 1'b0, ERR_NONE, 1'b0);
                scan_phase  = PH_PAYLOAD;
                payload_due = len;
                return 1'b1;
            end
            PH_VARINT:
            begin
                if (n < VARINT_MAX_BYTES)
                    scan_acc = scan_acc | (low << (7 * n));
                scan_count = n + 4'd1;
                if (more)
                begin
                    if (fin)
                    begin
                        ob = close_field(cur_field, cur_wire, '0, 1'b0, ERR_TRUNCATED, fin);
                        return 1'b1;
                    end
                    if (scan_count >= VARINT_MAX_BYTES)
                    begin
                        ob = close_field(cur_field, cur_wire, '0, 1'b0, ERR_TOO_LONG, fin);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                ob = close_field(cur_field, cur_wire, scan_acc, 1'b0, ERR_NONE, fin);
                return 1'b1;
            end
            PH_FIX64, PH_FIX32:
            begin
                need = (scan_phase == PH_FIX64) ? FIX64_BYTES : FIX32_BYTES;
                if (n < FIX64_BYTES)
                    scan_acc = scan_acc | (64'(b) << (8 * n));
                scan_count = n + 4'd1;
                if (scan_count >= need)
                begin
                    ob = close_field(cur_field, cur_wire, scan_acc, 1'b0, ERR_NONE, fin);
                    return 1'b1;
                end
                if (fin)
                begin
                    ob = close_field(cur_field, cur_wire, '0, 1'b0, ERR_TRUNCATED, fin);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_PAYLOAD:
            begin
                left = payload_due - 32'd1;
                if (left == 32'd0 || fin)
                begin
                    ob = close_field(cur_field, cur_wire, 64'(b), 1'b1,
                                     (left == 32'd0) ? ERR_NONE : ERR_TRUNCATED, fin);
                    return 1'b1;
                end
                ob = close_field(cur_field, cur_wire, 64'(b), 1'b1, ERR_NONE, 1'b0);
                scan_phase  = PH_PAYLOAD;
                payload_due = left;
                return 1'b1;
            end
            default:
            begin
                if (fin)
                begin
                    scan_phase  = PH_TAG;
                    scan_count  = '0;
                    scan_acc    = '0;
                    payload_due = '0;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // byte channel
    // ------------------------------------------------------------------
    task automatic send_byte(input in_beat_t beat);
        out_beat_t ob;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid = 1'b1;
        byte_beat  = beat;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        if (decode_byte(beat, ob))
            expected_fields.push_back(ob);
        bytes_sent++;
    endtask

    task automatic send_message();
        in_beat_t beat;
        int i;
        for (i = 0; i < msg_bytes.size(); i++)
        begin
            beat.data_byte = msg_bytes[i];
            beat.last_byte = (i == msg_bytes.size() - 1);
            send_byte(beat);
        end
        msg_bytes.delete();
    endtask

    // ------------------------------------------------------------------
    // message building
    // ------------------------------------------------------------------
    function automatic int varint_len(input logic [63:0] v);
        int k;
        k = 1;
        while (k < 10 && (v >> (7 * k)) != 64'd0)
            k++;
        return k;
    endfunction

    task automatic put_varint(input logic [63:0] v, input int nbytes);
        logic [7:0] chunk;
        int i;
        for (i = 0; i < nbytes; i++)
        begin
            chunk = (7 * i < 64) ? 8'((v >> (7 * i)) & 64'h7f) : 8'h00;
            if (i < nbytes - 1)
                chunk = chunk | CONT_MASK;
            msg_bytes.push_back(chunk);
        end
    endtask

    task automatic put_random_bytes(input int count);
        int i;
        for (i = 0; i < count; i++)
            msg_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [63:0] random_value();
        case ($urandom_range(4))
            0: return 64'd0;
            1: return '1;
            2: return 64'($urandom);
            default: return {$urandom, $urandom} >> $urandom_range(63);
        endcase
    endfunction

    task automatic add_field();
        logic [28:0] fn;
        logic [2:0]  wt;
        logic [63:0] v;
        logic [31:0] len;
        int          k;
        int          r;
        case ($urandom_range(3))
            0: fn = 29'($urandom_range(15));
            1: fn = 29'($urandom_range(2047));
            2: fn = 29'($urandom);
            default: fn = '1;
        endcase
        if ($urandom_range(99) < 90)
        begin
            case ($urandom_range(3))
                0: wt = WT_VARINT;
                1: wt = WT_FIX64;
                2: wt = WT_LENGTH;
                default: wt = WT_FIX32;
            endcase
        end
        else
        begin
            wt = 3'($urandom_range(7));
            while (wt == WT_VARINT || wt == WT_FIX64 || wt == WT_LENGTH || wt == WT_FIX32)
                wt = 3'($urandom_range(7));
        end
        k = varint_len(64'({fn, wt}));
        r = $urandom_range(99);
        if (r < 8)
            k = $urandom_range(5, k);
        else if (r < 11)
            k = 6;
        put_varint(64'({fn, wt}), k);
        if (k > 5)
            return;
        case (wt)
            WT_VARINT:
            begin
                v = random_value();
                k = varint_len(v);
                r = $urandom_range(99);
                if (r < 10)
                    k = $urandom_range(10, k);
                else if (r < 15)
                    k = 11;
                put_varint(v, k);
            end
            WT_FIX64: put_random_bytes(8);
            WT_FIX32: put_random_bytes(4);
            WT_LENGTH:
            begin
                r = $urandom_range(99);
                if (r < 85)
                    len = $urandom_range(5);
                else if (r < 95)
                    len = $urandom_range(20, 6);
                else
                    len = $urandom;
                k = varint_len(64'(len));
                r = $urandom_range(99);
                if (r < 10)
                    k = $urandom_range(5, k);
                else if (r < 14)
                    k = 6;
                put_varint(64'(len), k);
                put_random_bytes((len > 20) ? $urandom_range(6, 1) : int'(len));
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge clk)
        field_ready = ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
    begin : check_results
        out_beat_t want;
        if (rst_n && field_valid && field_ready)
        begin
            if (expected_fields.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, field_beat);
                fail_count++;
            end
            else
            begin
                want = expected_fields.pop_front();
                compare_field("field_number", 64'(want.field_number),
                              64'(field_beat.field_number));
                compare_field("wtype", 64'(want.wtype), 64'(field_beat.wtype));
                compare_field("value", want.value, field_beat.value);
                compare_field("is_payload", 64'(want.is_payload), 64'(field_beat.is_payload));
                compare_field("error_code", 64'(want.error_code), 64'(field_beat.error_code));
                compare_field("message_end", 64'(want.message_end),
                              64'(field_beat.message_end));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (field_valid && field_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes();
        // largest field number with an all-ones fixed32, then field zero
        msg_bytes = '{8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h00};
        send_message();
    endtask

    task automatic test_wire_types();
        msg_bytes = '{8'h08, 8'h96, 8'h01,
                      8'h11, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                      8'h1A, 8'h02, 8'hAA, 8'h55};
        send_message();
    endtask

    task automatic test_delimited_edges();
        msg_bytes = '{8'h12, 8'h00};
        send_message();
        msg_bytes = '{8'h12, 8'h05};
        send_message();
        msg_bytes = '{8'h12, 8'h03, 8'h41, 8'h42};
        send_message();
    endtask

    task automatic test_varint_errors();
        // continuation on the last byte, then an over-long tag and drain
        msg_bytes = '{8'h08, 8'h80};
        send_message();
        msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h07, 8'h55};
        send_message();
    endtask

    task automatic test_bad_wire_types();
        msg_bytes = '{8'h0B};
        send_message();
        msg_bytes = '{8'h0C, 8'h33};
        send_message();
        msg_bytes = '{8'h0E};
        send_message();
        msg_bytes = '{8'h0F, 8'h33};
        send_message();
        // tag alone, then a fixed32 cut short
        msg_bytes = '{8'h08};
        send_message();
        msg_bytes = '{8'h0D, 8'h01, 8'h02};
        send_message();
    endtask

    task automatic test_random_traffic(input int src_pct, input int dst_pct, input int count);
        int start;
        int keep;
        int i;
        sender_idle_pct = src_pct;
        sink_idle_pct   = dst_pct;
        start = bytes_sent;
        while (bytes_sent - start < count)
        begin
            if ($urandom_range(99) < 85)
            begin
                for (i = $urandom_range(4, 1); i > 0; i--)
                    add_field();
                if (msg_bytes.size() > 1 && $urandom_range(99) < 15)
                begin
                    keep = $urandom_range(msg_bytes.size() - 1, 1);
                    while (msg_bytes.size() > keep)
                        void'(msg_bytes.pop_back());
                end
            end
            else
                put_random_bytes($urandom_range(8, 1));
            send_message();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 16;
        sink_idle_pct   = 84;
        test_field_extremes();
        test_wire_types();
        test_delimited_edges();
        test_varint_errors();
        test_bad_wire_types();

        test_random_traffic(16, 84, RANDOM_BYTES);
        test_random_traffic(84, 16, RANDOM_BYTES);
        test_random_traffic(0, 0, RANDOM_BYTES);

        @(negedge clk);
        byte_valid = 1'b0;
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && expected_fields.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
